/* sv/gcc_pkg.sv */
package gcc_pkg;

  localparam int GRID_DIM_MAX_DEF = 16;
  localparam int MAX_CUBE_DEF     = 64;

  localparam logic [1:0] REG_GRID_X = 2'd0;
  localparam logic [1:0] REG_GRID_Y = 2'd1;
  localparam logic [1:0] REG_GRID_Z = 2'd2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  typedef struct packed {
    logic        action;
    logic [11:0] brick_index;
    logic        active;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [3:0] start_x;
    logic [3:0] start_y;
    logic [3:0] start_z;
    logic [4:0] cube_size;
  } out_item_t;

  // request from the sequencer to the map unit
  typedef struct packed {
    logic        wr;
    logic [11:0] addr;
    logic        wdata;
    logic        rd;
  } map_req_t;

endpackage

/* sv/greedy_cube_clustering_core.sv */
// Load: accepted in S_IDLE, loads can follow back to back. Fetch: data dependent;
// the first fetch after a restart copies the active bitmap into the unclaimed one (one entry a
// cycle), then each candidate corner is checked brick by brick, each claimed brick is cleared,
// the edge shrinks by one when a size runs out of corners, and then the result is offered.
// No item is accepted while a result waits. Reset: rst_n synchronous; a clearing pass
// zeroes the active bitmap, and no item is accepted until it ends.
module greedy_cube_clustering_core #(
  parameter int GRID_DIM_MAX = gcc_pkg::GRID_DIM_MAX_DEF,
  parameter int MAX_CUBE     = gcc_pkg::MAX_CUBE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gcc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gcc_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_wdata
);

  localparam int DEPTH = GRID_DIM_MAX * GRID_DIM_MAX * GRID_DIM_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = AW + 1;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_COPY  = 8'b00000100,
    S_NEXT  = 8'b00001000,
    S_RD    = 8'b00010000,
    S_CHK   = 8'b00100000,
    S_CLAIM = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  logic [4:0] gx_r, gy_r, gz_r;
  logic [4:0] dx, dy, dz;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] cp_r;
  logic       cp_vld_r;
  logic [4:0] sx_r, sy_r, sz_r, sx_nxt, sy_nxt, sz_nxt;
  logic [4:0] size_r, size_nxt;
  logic       started_r, started_nxt;
  logic [4:0] cx_r, cy_r, cz_r, cx_nxt, cy_nxt, cz_nxt;
  logic [4:0] ix_r, iy_r, iz_r, ix_nxt, iy_nxt, iz_nxt;
  logic [11:0] cell_r;
  logic [9:0] dxy_r;
  gcc_pkg::out_item_t res_r, res_nxt;
  logic       res_vld_r, res_vld_nxt;
  gcc_pkg::map_req_t act_req, unc_req;
  logic act_rdata, unc_rdata;
  logic [4:0] m;
  logic inner_last;

  function automatic logic [4:0] eff(input logic [4:0] r);
    if (r == 5'd0) return 5'd1;
    if (32'(r) > GRID_DIM_MAX) return 5'(GRID_DIM_MAX);
    return r;
  endfunction

  assign dx = eff(gx_r);
  assign dy = eff(gy_r);
  assign dz = eff(gz_r);

  always_comb begin
    m = (32'(dx) < MAX_CUBE) ? dx : 5'(MAX_CUBE);
    if (dy < m) m = dy;
    if (dz < m) m = dz;
  end

  gcc_map #(.DEPTH(DEPTH), .AW(AW)) u_map (
    .clk(clk), .act_req(act_req), .unc_req(unc_req),
    .act_rdata(act_rdata), .unc_rdata(unc_rdata)
  );

  assign in_ready  = (state_r == S_IDLE) && !res_vld_r;
  assign out_valid = res_vld_r;
  assign out_data  = res_r;

  // registers and restart on configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gx_r <= 5'd16; gy_r <= 5'd16; gz_r <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        gcc_pkg::REG_GRID_X: gx_r <= cfg_wdata;
        gcc_pkg::REG_GRID_Y: gy_r <= cfg_wdata;
        gcc_pkg::REG_GRID_Z: gz_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // linear cell address: ix + dx*iy + dx*dy*iz, with dx*dy registered first
  always_ff @(posedge clk) begin
    dxy_r  <= 10'(dx) * 10'(dy);
    cell_r <= 12'(32'(ix_r) + 32'(dx) * 32'(iy_r) + 32'(dxy_r) * 32'(iz_r));
  end

  // copy pipeline: unclaimed write follows in the cycle after the active read
  always_ff @(posedge clk) begin
    if (!rst_n) cp_vld_r <= 1'b0;
    else cp_vld_r <= (state_r == S_COPY) && (32'(cnt_r) < DEPTH);
    cp_r <= cnt_r;
  end

  assign inner_last = (ix_r == cx_r + size_r - 5'd1) && (iy_r == cy_r + size_r - 5'd1)
                      && (iz_r == cz_r + size_r - 5'd1);

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r;
    sx_nxt = sx_r; sy_nxt = sy_r; sz_nxt = sz_r; size_nxt = size_r;
    started_nxt = started_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r;
    ix_nxt = ix_r; iy_nxt = iy_r; iz_nxt = iz_r;
    res_nxt = res_r; res_vld_nxt = res_vld_r;
    act_req = '0; unc_req = '0;
    if (res_vld_r && out_ready) res_vld_nxt = 1'b0;
    if (cp_vld_r) begin
      unc_req.wr = 1'b1; unc_req.addr = 12'(cp_r); unc_req.wdata = act_rdata;
    end
    case (state_r)
      S_CLEAR: begin
        act_req.wr = 1'b1; act_req.addr = 12'(cnt_r); act_req.wdata = 1'b0;
        cnt_nxt = cnt_r + 1'b1;
        if (32'(cnt_r) == DEPTH - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_data.action == gcc_pkg::ACT_LOAD) begin
            if (32'(in_data.brick_index) < DEPTH) begin
              act_req.wr = 1'b1; act_req.addr = in_data.brick_index;
              act_req.wdata = in_data.active;
            end
            started_nxt = 1'b0;
          end else if (!started_r) begin
            cnt_nxt = '0; state_nxt = S_COPY;
          end else begin
            state_nxt = S_NEXT;
          end
        end
      end
      S_COPY: begin
        act_req.rd = 1'b1; act_req.addr = 12'(cnt_r);
        cnt_nxt = cnt_r + 1'b1;
        if (32'(cnt_r) == DEPTH) begin
          size_nxt = m; sx_nxt = '0; sy_nxt = '0; sz_nxt = '0;
          started_nxt = 1'b1; state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (size_r == 5'd0) begin
          res_nxt = '0; state_nxt = S_OUT;
        end else if (sz_r > dz - size_r) begin
          size_nxt = size_r - 5'd1; sx_nxt = '0; sy_nxt = '0; sz_nxt = '0;
        end else begin
          cx_nxt = sx_r; cy_nxt = sy_r; cz_nxt = sz_r;
          ix_nxt = sx_r; iy_nxt = sy_r; iz_nxt = sz_r;
          if (sx_r + 5'd1 > dx - size_r) begin
            sx_nxt = '0;
            if (sy_r + 5'd1 > dy - size_r) begin
              sy_nxt = '0; sz_nxt = sz_r + 5'd1;
            end else sy_nxt = sy_r + 5'd1;
          end else sx_nxt = sx_r + 5'd1;
          cnt_nxt = '0; state_nxt = S_RD;
        end
      end
      S_RD: begin
        // cell_r holds the address in the cycle after the index settles
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(1)) begin
          unc_req.rd = 1'b1; unc_req.addr = cell_r;
          cnt_nxt = '0; state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (!unc_rdata) state_nxt = S_NEXT;
        else if (inner_last) begin
          ix_nxt = cx_r; iy_nxt = cy_r; iz_nxt = cz_r; cnt_nxt = '0; state_nxt = S_CLAIM;
        end else begin
          state_nxt = S_RD;
          if (ix_r != cx_r + size_r - 5'd1) ix_nxt = ix_r + 5'd1;
          else begin
            ix_nxt = cx_r;
            if (iy_r != cy_r + size_r - 5'd1) iy_nxt = iy_r + 5'd1;
            else begin iy_nxt = cy_r; iz_nxt = iz_r + 5'd1; end
          end
        end
      end
      S_CLAIM: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(1)) begin
          unc_req.wr = 1'b1; unc_req.addr = cell_r; unc_req.wdata = 1'b0;
          cnt_nxt = '0;
          if (inner_last) begin
            res_nxt.found = 1'b1; res_nxt.start_x = cx_r[3:0];
            res_nxt.start_y = cy_r[3:0]; res_nxt.start_z = cz_r[3:0];
            res_nxt.cube_size = size_r; state_nxt = S_OUT;
          end else if (ix_r != cx_r + size_r - 5'd1) ix_nxt = ix_r + 5'd1;
          else begin
            ix_nxt = cx_r;
            if (iy_r != cy_r + size_r - 5'd1) iy_nxt = iy_r + 5'd1;
            else begin iy_nxt = cy_r; iz_nxt = iz_r + 5'd1; end
          end
        end
      end
      S_OUT: begin
        if (!res_vld_r) begin
          res_vld_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // any grid register write restarts the scan
    if (cfg_we && (cfg_index inside {gcc_pkg::REG_GRID_X, gcc_pkg::REG_GRID_Y,
                                     gcc_pkg::REG_GRID_Z})) started_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; cnt_r <= '0; started_r <= 1'b0; res_vld_r <= 1'b0;
      size_r <= '0; sx_r <= '0; sy_r <= '0; sz_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; started_r <= started_nxt;
      res_vld_r <= res_vld_nxt; size_r <= size_nxt;
      sx_r <= sx_nxt; sy_r <= sy_nxt; sz_r <= sz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt;
    ix_r <= ix_nxt; iy_r <= iy_nxt; iz_r <= iz_nxt;
    res_r <= res_nxt;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_found_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.found) |-> (out_data.cube_size != 5'd0))
    else $error("zero size cluster");
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data == '0)) else $error("dirty not found");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");

endmodule

/* sv/gcc_map.sv */
module gcc_map #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic              clk,
  input  gcc_pkg::map_req_t act_req,
  input  gcc_pkg::map_req_t unc_req,
  output logic              act_rdata,
  output logic              unc_rdata
);

  logic act_mem [DEPTH];
  logic unc_mem [DEPTH];

  // single-port bitmaps, registered reads
  always_ff @(posedge clk) begin
    if (act_req.wr) begin
      act_mem[act_req.addr[AW-1:0]] <= act_req.wdata;
    end
    if (act_req.rd) begin
      act_rdata <= act_mem[act_req.addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (unc_req.wr) begin
      unc_mem[unc_req.addr[AW-1:0]] <= unc_req.wdata;
    end
    if (unc_req.rd) begin
      unc_rdata <= unc_mem[unc_req.addr[AW-1:0]];
    end
  end

endmodule

/* test/greedy_cube_clustering_core_tb.sv */
`timescale 1ns / 100ps

module greedy_cube_clustering_core_tb;

  localparam int          MAP_CELLS   = 4096;
  localparam int          CYCLE_LIMIT = 20000000;
  localparam int          DRAIN_WAIT  = 64;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  gcc_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  gcc_pkg::out_item_t out_data;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [4:0] cfg_wdata;

  // cluster predictor state
  logic [4:0] grid_reg [3];
  bit   active_bits [MAP_CELLS];
  bit   free_bits [MAP_CELLS];
  int   next_x, next_y, next_z;
  int   edge_len;
  bit   scan_live;

  gcc_pkg::out_item_t clusters_due[$];
  int        errors;
  int        cycles;
  int        tx_idle;
  int        rx_idle;
  int        hold_req;
  int        hold_cnt;

  greedy_cube_clustering_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int dim_of(logic [4:0] r);
    if (r < 1) return 1;
    if (r > gcc_pkg::GRID_DIM_MAX_DEF) return gcc_pkg::GRID_DIM_MAX_DEF;
    return int'(r);
  endfunction

  function automatic void restart_scan();
    scan_live = 0;
    next_x = 0;
    next_y = 0;
    next_z = 0;
    edge_len = 0;
  endfunction

  function automatic bit cube_is_free(int x, int y, int z, int s, int dx, int dy);
    for (int k = z; k < z + s; k++)
      for (int j = y; j < y + s; j++)
        for (int i = x; i < x + s; i++)
          if (!free_bits[(i + dx * j + dx * dy * k) % MAP_CELLS]) return 0;
    return 1;
  endfunction

  function automatic void claim_cube(int x, int y, int z, int s, int dx, int dy);
    for (int k = z; k < z + s; k++)
      for (int j = y; j < y + s; j++)
        for (int i = x; i < x + s; i++)
          free_bits[(i + dx * j + dx * dy * k) % MAP_CELLS] = 0;
  endfunction

  // next greedy cluster, or an all-zero result once the scan is exhausted
  function automatic gcc_pkg::out_item_t next_cluster();
    gcc_pkg::out_item_t r;
    int dx, dy, dz, x, y, z, s;
    r  = '0;
    dx = dim_of(grid_reg[0]);
    dy = dim_of(grid_reg[1]);
    dz = dim_of(grid_reg[2]);
    if (!scan_live) begin
      free_bits = active_bits;
      edge_len = gcc_pkg::MAX_CUBE_DEF;
      if (dx < edge_len) edge_len = dx;
      if (dy < edge_len) edge_len = dy;
      if (dz < edge_len) edge_len = dz;
      next_x = 0;
      next_y = 0;
      next_z = 0;
      scan_live = 1;
    end
    while (edge_len >= 1) begin
      s = edge_len;
      if (next_z > dz - s) begin
        edge_len--;
        next_x = 0;
        next_y = 0;
        next_z = 0;
        continue;
      end
      x = next_x;
      y = next_y;
      z = next_z;
      next_x++;
      if (next_x > dx - s) begin
        next_x = 0;
        next_y++;
        if (next_y > dy - s) begin
          next_y = 0;
          next_z++;
        end
      end
      if (cube_is_free(x, y, z, s, dx, dy)) begin
        claim_cube(x, y, z, s, dx, dy);
        r.found     = 1'b1;
        r.start_x   = x[3:0];
        r.start_y   = y[3:0];
        r.start_z   = z[3:0];
        r.cube_size = s[4:0];
        return r;
      end
    end
    return r;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("greedy_cube_clustering_core_tb NOT OK");
      $finish;
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // check each result transfer against the oldest expected cluster
  always @(posedge clk) begin
    gcc_pkg::out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (clusters_due.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_data);
        errors++;
      end else begin
        exp_r = clusters_due.pop_front();
        if (exp_r.found !== out_data.found ||
            exp_r.start_x !== out_data.start_x ||
            exp_r.start_y !== out_data.start_y ||
            exp_r.start_z !== out_data.start_z ||
            exp_r.cube_size !== out_data.cube_size) begin
          $display("%0t mismatch expected %p actual %p", $time, exp_r, out_data);
          errors++;
        end
      end
    end
  end

  // offer one item, hold it until the transfer, then update the predictor
  task automatic send_item(logic act, logic [11:0] idx, logic flag);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle && gap < 20) begin
      @(negedge clk);
      in_valid <= 1'b0;
      gap++;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{action: act, brick_index: idx, active: flag};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act == gcc_pkg::ACT_LOAD) begin
      active_bits[idx] = flag;
      restart_scan();
    end else begin
      clusters_due.insert(clusters_due.size(), next_cluster());
    end
  endtask

  task automatic load_brick(int idx, bit flag);
    send_item(gcc_pkg::ACT_LOAD, idx[11:0], flag);
  endtask

  task automatic fetch_cluster();
    send_item(gcc_pkg::ACT_FETCH, 12'($urandom), 1'($urandom));
  endtask

  // drop valid and wait until the block has drained
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (clusters_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx != REG_UNUSED) begin
      grid_reg[idx] = val;
      restart_scan();
    end
  endtask

  task automatic set_grid(int x, int y, int z);
    write_reg(gcc_pkg::REG_GRID_X, x[4:0]);
    write_reg(gcc_pkg::REG_GRID_Y, y[4:0]);
    write_reg(gcc_pkg::REG_GRID_Z, z[4:0]);
  endtask

  // empty full grid, full small cube, clamped dimensions, unused index, sparse grid
  task automatic test_directed();
    fetch_cluster();
    fetch_cluster();
    set_grid(2, 2, 2);
    for (int i = 0; i < 8; i++) load_brick(i, 1);
    fetch_cluster();
    fetch_cluster();
    fetch_cluster();
    load_brick(3, 0);
    fetch_cluster();
    fetch_cluster();
    load_brick(4095, 1);
    load_brick(4095, 0);
    write_reg(gcc_pkg::REG_GRID_X, 5'd0);
    write_reg(gcc_pkg::REG_GRID_Y, 5'd31);
    write_reg(gcc_pkg::REG_GRID_Z, 5'd3);
    fetch_cluster();
    fetch_cluster();
    write_reg(REG_UNUSED, 5'd31);
    fetch_cluster();
    set_grid(3, 2, 4);
    for (int i = 0; i < 24; i += 2) load_brick(i, 1);
    fetch_cluster();
    fetch_cluster();
  endtask

  // hold the receiver off while fetches keep coming
  task automatic test_backpressure();
    set_grid(4, 4, 4);
    for (int i = 0; i < 12; i++) load_brick($urandom_range(63), 1);
    hold_req = 9000;
    for (int i = 0; i < 8; i++) fetch_cluster();
    settle();
  endtask

  // episodes: set a grid, load bricks, fetch a random number of times, with some noise
  task automatic test_random();
    int sent, cells, nload, nfetch, dx, dy, dz;
    sent = 0;
    while (sent < 500) begin
      if (sent < 167) begin
        tx_idle = 15;
        rx_idle = 67;
      end else if (sent < 334) begin
        tx_idle = 67;
        rx_idle = 15;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      if ($urandom_range(24) == 0) begin
        dx = 16;
        dy = $urandom_range(1, 16);
        dz = $urandom_range(1, 3);
      end else begin
        dx = $urandom_range(1, 6);
        dy = $urandom_range(1, 6);
        dz = $urandom_range(1, 6);
      end
      set_grid(dx, dy, dz);
      cells = dx * dy * dz;
      nload = $urandom_range(0, (cells < 16) ? cells : 16);
      for (int i = 0; i < nload; i++) begin
        if ($urandom_range(3) == 0) begin
          for (int j = 0; j < cells && j < 8; j++) load_brick(j, 1);
          sent += (cells < 8) ? cells : 8;
        end
        load_brick($urandom_range(cells - 1), $urandom_range(9) != 0);
        sent++;
      end
      nfetch = $urandom_range(2, 12);
      for (int i = 0; i < nfetch; i++) begin
        if ($urandom_range(19) == 0) begin
          load_brick($urandom_range(4095), $urandom_range(1));
        end else begin
          fetch_cluster();
        end
        sent++;
      end
    end
    tx_idle = 0;
    rx_idle = 0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    errors    = 0;
    cycles    = 0;
    tx_idle   = 0;
    rx_idle   = 0;
    hold_req  = 0;
    hold_cnt  = 0;
    grid_reg[0] = 5'd16;
    grid_reg[1] = 5'd16;
    grid_reg[2] = 5'd16;
    foreach (active_bits[i]) active_bits[i] = 0;
    foreach (free_bits[i]) free_bits[i] = 0;
    restart_scan();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    test_directed();
    test_backpressure();
    test_random();
    settle();

    if (errors == 0) begin
      $display("greedy_cube_clustering_core_tb OK");
    end else begin
      $display("greedy_cube_clustering_core_tb NOT OK");
    end
    $finish;
  end

endmodule
